[rtl/core/risl_pkg.sv]
// ----------------------------------------------------------------------------
// risl_pkg
// Shared types, command codes, sequencer states and sine table functions
// for the range image segment labeling block.
// ----------------------------------------------------------------------------
package risl_pkg;

   localparam int ROWS_DEF       = 64;
   localparam int COLS_DEF       = 870;
   localparam int REACH_DEF      = 2;
   localparam int RANGE_BITS_DEF = 16;

   localparam int UPPER_ROWS = 32;
   localparam longint DEG12_U    = 2400000;
   localparam longint COL_STEP_U = 82758;
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_LABEL = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_RESULT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_POP,
      ST_Q_FETCH,
      ST_Q_RANGE,
      ST_NB,
      ST_NB_WAIT,
      ST_MUL_A,
      ST_MUL_B
   } state_type;

   typedef struct packed {
      logic        valid;
      cmd_type     cmd;
      logic [5:0]  pixel_row;
      logic [9:0]  pixel_col;
      logic [15:0] range_value;
   } req_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] value;
   } rsp_type;

   // Q1.15 sine of an angle given in 1/200000 degree, by a Taylor series in Q2.30
   function automatic logic [15:0] sine_q15(input longint unsigned u);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      x  = (u * PI_Q30 + 64'd18000000) / 64'd36000000;
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      t  = ((t * x2) >> 30) / 64'd6;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd20;
      s  = s + t;
      t  = ((t * x2) >> 30) / 64'd42;
      s  = s - t;
      t  = ((t * x2) >> 30) / 64'd72;
      s  = s + t;
      return 16'((s + 64'd16384) >> 15);
   endfunction

   function automatic longint beam_elevation(input int r);
      if (r < UPPER_ROWS) begin
         return longint'(400000) - longint'(65625) * longint'(r);
      end
      return longint'(-1774000) - longint'(100000) * longint'(r - UPPER_ROWS);
   endfunction

   function automatic logic [15:0] row_sine(input int r, input int k);
      longint d;
      d = beam_elevation(r) - beam_elevation(r + k);
      if (d < 0) begin
         d = -d;
      end
      return sine_q15(longint'(DEG12_U + d));
   endfunction

   function automatic logic [15:0] col_sine(input int k);
      return sine_q15(longint'(DEG12_U + COL_STEP_U * longint'(k)));
   endfunction

endpackage

[rtl/core/risl_mul.sv]
// ----------------------------------------------------------------------------
// risl_mul
// Shared registered multiplier used for both sides of the joining test.
// ----------------------------------------------------------------------------
module risl_mul #(
   parameter int A_BITS = risl_pkg::RANGE_BITS_DEF
) (
   input  logic                 clock,
   input  logic [A_BITS-1:0]    mul_a,
   input  logic [15:0]          mul_b,
   output logic [A_BITS+15:0]   mul_p
);
   import risl_pkg::*;

   logic [A_BITS+15:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= (A_BITS+16)'(mul_a) * (A_BITS+16)'(mul_b);
   end

   assign mul_p = p_ff;

endmodule

[rtl/core/risl_engine.sv]
// ----------------------------------------------------------------------------
// risl_engine
// Image memories, flood queue and the labeling sequencer around one
// shared multiplier.
// ----------------------------------------------------------------------------
module risl_engine #(
   parameter int ROWS       = risl_pkg::ROWS_DEF,
   parameter int COLS       = risl_pkg::COLS_DEF,
   parameter int REACH      = risl_pkg::REACH_DEF,
   parameter int RANGE_BITS = risl_pkg::RANGE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  risl_pkg::req_type req,
   output logic              ready,
   output risl_pkg::rsp_type rsp,
   input  logic              rsp_ready
);
   import risl_pkg::*;

   localparam int NPIX = ROWS * COLS;
   localparam int IW   = $clog2(NPIX);
   localparam int QW   = $clog2(NPIX + 1);
   localparam int RW   = $clog2(ROWS);
   localparam int CW   = $clog2(COLS);
   localparam int AW   = $clog2(REACH + 1);
   localparam int KW   = AW + 1;
   localparam int EW   = RW + CW + IW;
   localparam int PW   = RANGE_BITS + 16;
   localparam logic signed [KW-1:0] K_LO = KW'(-REACH);
   localparam logic signed [KW-1:0] K_HI = KW'(REACH);
   localparam logic [IW-1:0] LAST_PIX = IW'(NPIX - 1);
   localparam logic [15:0] SINE12 = sine_q15(DEG12_U);

   // sine tables
   logic [15:0] col_sine_tab [REACH+1];
   logic [15:0] row_sine_tab [ROWS][REACH+1];

   for (genvar gk = 0; gk <= REACH; gk++) begin : g_col
      localparam logic [15:0] CS = col_sine(gk);
      assign col_sine_tab[gk] = CS;
      for (genvar gr = 0; gr < ROWS; gr++) begin : g_row
         localparam logic [15:0] RS = row_sine(gr, gk);
         assign row_sine_tab[gr][gk] = RS;
      end
   end

   // memories
   logic [RANGE_BITS-1:0] range_mem [NPIX];
   logic [15:0]           label_mem [NPIX];
   logic                  vis_mem   [NPIX];
   logic [EW-1:0]         queue_mem [NPIX];

   logic                  r_we, l_we, v_we, v_wd, q_we;
   logic [IW-1:0]         r_wa, l_wa, v_wa, q_wa, r_ra, l_ra, v_ra, q_ra;
   logic [RANGE_BITS-1:0] r_wd, r_rd;
   logic [15:0]           l_wd, l_rd;
   logic                  v_rd;
   logic [EW-1:0]         q_wd, q_rd;

   always_ff @(posedge clock) begin
      if (r_we) begin
         range_mem[r_wa] <= r_wd;
      end
      r_rd <= range_mem[r_ra];
   end

   always_ff @(posedge clock) begin
      if (l_we) begin
         label_mem[l_wa] <= l_wd;
      end
      l_rd <= label_mem[l_ra];
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vis_mem[v_wa] <= v_wd;
      end
      v_rd <= vis_mem[v_ra];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_wa] <= q_wd;
      end
      q_rd <= queue_mem[q_ra];
   end

   // shared multiplier
   logic [RANGE_BITS-1:0] mul_a;
   logic [15:0]           mul_b;
   logic [PW-1:0]         mul_p;

   risl_mul #(.A_BITS(RANGE_BITS)) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // sequencer registers
   state_type             state_ff, state_in;
   logic [IW-1:0]         clr_ff, clr_in;
   logic                  clr_range_ff, clr_range_in;
   logic                  go_label_ff, go_label_in;
   logic [IW-1:0]         p_ff, p_in;
   logic [RW-1:0]         sr_ff, sr_in;
   logic [CW-1:0]         sc_ff, sc_in;
   logic [QW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [15:0]           label_ff, label_in;
   logic [IW-1:0]         q_idx_ff, q_idx_in;
   logic [RW-1:0]         q_row_ff, q_row_in;
   logic [CW-1:0]         q_col_ff, q_col_in;
   logic [RANGE_BITS-1:0] rq_ff, rq_in;
   logic                  dir_ff, dir_in;
   logic signed [KW-1:0]  k_ff, k_in;
   logic [IW-1:0]         n_idx_ff, n_idx_in;
   logic [RW-1:0]         n_row_ff, n_row_in;
   logic [CW-1:0]         n_col_ff, n_col_in;
   logic [15:0]           s_ff, s_in;
   logic [RANGE_BITS-1:0] d1_ff, d1_in;
   logic [PW-1:0]         prod1_ff, prod1_in;
   logic [15:0]           res_ff, res_in;
   logic                  inside_ff, inside_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_range_ff <= 1'b1;
         go_label_ff  <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         label_ff     <= 16'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_range_ff <= clr_range_in;
         go_label_ff  <= go_label_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         label_ff     <= label_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      sr_ff     <= sr_in;
      sc_ff     <= sc_in;
      q_idx_ff  <= q_idx_in;
      q_row_ff  <= q_row_in;
      q_col_ff  <= q_col_in;
      rq_ff     <= rq_in;
      dir_ff    <= dir_in;
      k_ff      <= k_in;
      n_idx_ff  <= n_idx_in;
      n_row_ff  <= n_row_in;
      n_col_ff  <= n_col_in;
      s_ff      <= s_in;
      d1_ff     <= d1_in;
      prod1_ff  <= prod1_in;
      res_ff    <= res_in;
      inside_ff <= inside_in;
   end

   // request address
   logic        req_inside;
   logic [31:0] req_idx;
   assign req_inside = (32'(req.pixel_row) < 32'(ROWS)) && (32'(req.pixel_col) < 32'(COLS));
   assign req_idx    = 32'(req.pixel_row) * 32'(COLS) + 32'(req.pixel_col);

   logic [23:0] req_range_ext;
   assign req_range_ext = {8'd0, req.range_value};

   // neighbor under test
   logic signed [31:0] nr_s, nc_s, ni_s;
   logic               nb_ok;
   logic [KW-1:0]      k_abs_w;
   logic [AW-1:0]      k_abs;
   logic [RW-1:0]      srow;
   logic [15:0]        nb_sine;

   always_comb begin
      nr_s    = 32'(q_row_ff) + (dir_ff ? 32'(k_ff) : 32'sd0);
      nc_s    = 32'(q_col_ff) + (dir_ff ? 32'sd0 : 32'(k_ff));
      ni_s    = 32'(q_idx_ff) + (dir_ff ? 32'(k_ff) * 32'(COLS) : 32'(k_ff));
      nb_ok   = (k_ff != '0) && (nr_s >= 0) && (nr_s < 32'(ROWS))
                && (nc_s >= 0) && (nc_s < 32'(COLS));
      k_abs_w = (k_ff < 0) ? KW'(-k_ff) : KW'(k_ff);
      k_abs   = k_abs_w[AW-1:0];
      srow    = (k_ff < 0) ? nr_s[RW-1:0] : q_row_ff;
      nb_sine = dir_ff ? row_sine_tab[srow][k_abs] : col_sine_tab[k_abs];
   end

   // next offset after the current one
   state_type            adv_state;
   logic                 adv_dir;
   logic signed [KW-1:0] adv_k;

   always_comb begin
      adv_state = ST_NB;
      adv_dir   = dir_ff;
      adv_k     = k_ff + KW'(1);
      if (k_ff == K_HI) begin
         if (!dir_ff) begin
            adv_dir = 1'b1;
            adv_k   = K_LO;
         end else begin
            adv_state = ST_POP;
         end
      end
   end

   logic [RANGE_BITS-1:0] rn;
   assign rn = r_rd;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_range_in = clr_range_ff;
      go_label_in  = go_label_ff;
      p_in         = p_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      label_in     = label_ff;
      q_idx_in     = q_idx_ff;
      q_row_in     = q_row_ff;
      q_col_in     = q_col_ff;
      rq_in        = rq_ff;
      dir_in       = dir_ff;
      k_in         = k_ff;
      n_idx_in     = n_idx_ff;
      n_row_in     = n_row_ff;
      n_col_in     = n_col_ff;
      s_in         = s_ff;
      d1_in        = d1_ff;
      prod1_in     = prod1_ff;
      res_in       = res_ff;
      inside_in    = inside_ff;

      r_we = 1'b0;  r_wa = clr_ff;  r_wd = '0;  r_ra = p_ff;
      l_we = 1'b0;  l_wa = clr_ff;  l_wd = '0;  l_ra = req_idx[IW-1:0];
      v_we = 1'b0;  v_wa = clr_ff;  v_wd = 1'b0; v_ra = p_ff;
      q_we = 1'b0;  q_wa = tail_ff[IW-1:0]; q_wd = {n_row_ff, n_col_ff, n_idx_ff};
      q_ra = head_ff[IW-1:0];
      mul_a = '0;
      mul_b = '0;
      ready = 1'b0;
      rsp.valid = 1'b0;
      rsp.value = res_ff;

      case (state_ff)
         ST_CLEAR: begin
            r_we = clr_range_ff;
            l_we = 1'b1;
            v_we = 1'b1;
            clr_in = clr_ff + IW'(1);
            if (clr_ff == LAST_PIX) begin
               clr_in = '0;
               if (go_label_ff) begin
                  p_in     = '0;
                  sr_in    = '0;
                  sc_in    = '0;
                  label_in = 16'd1;
                  state_in = ST_SCAN_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_IDLE: begin
            ready = 1'b1;
            if (req.valid) begin
               case (req.cmd)
                  CMD_CLEAR: begin
                     clr_range_in = 1'b1;
                     go_label_in  = 1'b0;
                     label_in     = 16'd1;
                     state_in     = ST_CLEAR;
                  end
                  CMD_LOAD: begin
                     r_we = req_inside;
                     r_wa = req_idx[IW-1:0];
                     r_wd = req_range_ext[RANGE_BITS-1:0];
                  end
                  CMD_LABEL: begin
                     clr_range_in = 1'b0;
                     go_label_in  = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  default: begin
                     inside_in = req_inside;
                     state_in  = ST_READ_WAIT;
                  end
               endcase
            end
         end

         ST_READ_WAIT: begin
            res_in   = inside_ff ? l_rd : 16'd0;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            rsp.valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end

         ST_SCAN_CHK, ST_POP: begin
            if (state_ff == ST_SCAN_CHK && !v_rd && r_rd != '0) begin
               // seed a new flood
               q_we     = 1'b1;
               q_wa     = '0;
               q_wd     = {sr_ff, sc_ff, p_ff};
               v_we     = 1'b1;
               v_wa     = p_ff;
               v_wd     = 1'b1;
               head_in  = '0;
               tail_in  = QW'(1);
               state_in = ST_POP;
            end else if (state_ff == ST_POP && head_ff < tail_ff) begin
               head_in  = head_ff + QW'(1);
               state_in = ST_Q_FETCH;
            end else begin
               if (state_ff == ST_POP) begin
                  label_in = label_ff + 16'd1;
               end
               // advance the raster scan
               if (p_ff == LAST_PIX) begin
                  res_in   = label_in - 16'd1;
                  state_in = ST_RESULT;
               end else begin
                  p_in = p_ff + IW'(1);
                  if (32'(sc_ff) == 32'(COLS - 1)) begin
                     sc_in = '0;
                     sr_in = sr_ff + RW'(1);
                  end else begin
                     sc_in = sc_ff + CW'(1);
                  end
                  state_in = ST_SCAN_RD;
               end
            end
         end

         ST_Q_FETCH: begin
            {q_row_in, q_col_in, q_idx_in} = q_rd;
            r_ra = q_rd[IW-1:0];
            l_we = 1'b1;
            l_wa = q_rd[IW-1:0];
            l_wd = label_ff;
            state_in = ST_Q_RANGE;
         end

         ST_Q_RANGE: begin
            rq_in    = r_rd;
            dir_in   = 1'b0;
            k_in     = K_LO;
            state_in = ST_NB;
         end

         ST_NB: begin
            if (nb_ok) begin
               r_ra     = ni_s[IW-1:0];
               v_ra     = ni_s[IW-1:0];
               n_idx_in = ni_s[IW-1:0];
               n_row_in = nr_s[RW-1:0];
               n_col_in = nc_s[CW-1:0];
               s_in     = nb_sine;
               state_in = ST_NB_WAIT;
            end else begin
               dir_in   = adv_dir;
               k_in     = adv_k;
               state_in = adv_state;
            end
         end

         ST_NB_WAIT: begin
            if (v_rd) begin
               dir_in   = adv_dir;
               k_in     = adv_k;
               state_in = adv_state;
            end else begin
               // smaller range times the offset sine
               d1_in    = (rq_ff > rn) ? rq_ff : rn;
               mul_a    = (rq_ff > rn) ? rn : rq_ff;
               mul_b    = s_ff;
               state_in = ST_MUL_A;
            end
         end

         ST_MUL_A: begin
            prod1_in = mul_p;
            mul_a    = d1_ff;
            mul_b    = SINE12;
            state_in = ST_MUL_B;
         end

         ST_MUL_B: begin
            if (prod1_ff > mul_p && tail_ff < QW'(NPIX)) begin
               q_we    = 1'b1;
               v_we    = 1'b1;
               v_wa    = n_idx_ff;
               v_wd    = 1'b1;
               tail_in = tail_ff + QW'(1);
            end
            dir_in   = adv_dir;
            k_in     = adv_k;
            state_in = adv_state;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/range_image_segment_labeling_top.sv]
// ----------------------------------------------------------------------------
// range_image_segment_labeling_top
// Command port and result register of the range image segment labeler.
// ----------------------------------------------------------------------------
// A word carries one command. Loads are taken one per cycle while the engine
// is idle. A read holds the command port through a registered label read,
// the result hand-off and the return to idle; its result passes the engine's
// result register and then the output register, and the port stays stalled
// longer while an earlier result waits unaccepted in the output register.
// Clear sweeps the whole image at one pixel per cycle, and the same sweep
// runs once after reset, during which no word is taken. Labeling first sweeps
// labels and visited marks, then scans every pixel through a read state and a
// check state. Each flooded pixel passes pop, fetch and range states plus one
// neighbor state per offset slot (2*(2*REACH+1) slots, offset zero and
// off-image slots included); a neighbor that is tried adds a wait state, and
// two multiply states when the joining test runs, paced by the single shared
// multiplier used twice per test. A flood ends with one more pop. One command
// is worked on at a time; a finished result waits in the output register.
module range_image_segment_labeling_top #(
   parameter int ROWS       = risl_pkg::ROWS_DEF,
   parameter int COLS       = risl_pkg::COLS_DEF,
   parameter int REACH      = risl_pkg::REACH_DEF,
   parameter int RANGE_BITS = risl_pkg::RANGE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_pixel_row,
   input  logic [9:0]  req_pixel_col,
   input  logic [15:0] req_range_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value
);
   import risl_pkg::*;

   req_type eng_req;
   rsp_type eng_rsp;
   logic    eng_ready;
   logic    out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_value_ff, rsp_value_in;

   always_comb begin
      eng_req.valid       = req_valid;
      eng_req.cmd         = cmd_type'(req_cmd);
      eng_req.pixel_row   = req_pixel_row;
      eng_req.pixel_col   = req_pixel_col;
      eng_req.range_value = req_range_value;
   end

   risl_engine #(
      .ROWS       (ROWS),
      .COLS       (COLS),
      .REACH      (REACH),
      .RANGE_BITS (RANGE_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req       (eng_req),
      .ready     (eng_ready),
      .rsp       (eng_rsp),
      .rsp_ready (out_free)
   );

   assign req_stall = !eng_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (out_free) begin
         rsp_valid_in = eng_rsp.valid;
         if (eng_rsp.valid) begin
            rsp_value_in = eng_rsp.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

[tb/tb_range_image_segment_labeling_top.sv]
// ----------------------------------------------------------------------------
// tb_range_image_segment_labeling_top
// Self-checking bench for the range image segment labeler: directed corner
// words, then blob-shaped loads, labeling runs and label reads, with random
// idle gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_range_image_segment_labeling_top;
   import risl_pkg::*;

   localparam int ROWS  = ROWS_DEF;
   localparam int COLS  = COLS_DEF;
   localparam int REACH = REACH_DEF;
   localparam int NPIX  = ROWS * COLS;

   class label_scoreboard;
      bit [15:0] ranges[NPIX];
      bit [15:0] labels[NPIX];
      bit        seen[NPIX];
      int        flood[NPIX];
      int        flood_tail;
      bit [15:0] pending[$];
      bit [15:0] sin12;
      bit [15:0] col_sin[REACH+1];
      bit [15:0] row_sin[ROWS][REACH+1];
      int        errors;
      int        results;
      int        label_runs;

      function new();
         longint d;
         sin12 = q15_sine(64'd2400000);
         for (int k = 0; k <= REACH; k++) begin
            col_sin[k] = q15_sine(64'd2400000 + 64'd82758 * k);
         end
         for (int r = 0; r < ROWS; r++) begin
            for (int k = 0; k <= REACH; k++) begin
               d = elevation(r) - elevation(r + k);
               if (d < 0) begin
                  d = -d;
               end
               row_sin[r][k] = q15_sine(64'd2400000 + longint'(d));
            end
         end
      endfunction

      // Taylor sine in Q2.30 radians, rounded to Q1.15
      function bit [15:0] q15_sine(longint unsigned u);
         longint unsigned x, x2, term, acc;
         x    = (u * 64'd3373259426 + 64'd18000000) / 64'd36000000;
         x2   = (x * x) >> 30;
         term = x;
         acc  = x;
         term = ((term * x2) >> 30) / 6;
         acc  = acc - term;
         term = ((term * x2) >> 30) / 20;
         acc  = acc + term;
         term = ((term * x2) >> 30) / 42;
         acc  = acc - term;
         term = ((term * x2) >> 30) / 72;
         acc  = acc + term;
         return 16'((acc + 64'd16384) >> 15);
      endfunction

      function longint elevation(int r);
         if (r < 32) begin
            return 64'sd400000 - 64'sd65625 * r;
         end
         return -64'sd1774000 - 64'sd100000 * (r - 32);
      endfunction

      function void try_join(int src, int dst, bit [15:0] s);
         longint unsigned hi, lo;
         if (seen[dst] || flood_tail >= NPIX) begin
            return;
         end
         hi = (ranges[src] > ranges[dst]) ? ranges[src] : ranges[dst];
         lo = (ranges[src] > ranges[dst]) ? ranges[dst] : ranges[src];
         if (lo * s > hi * sin12) begin
            flood[flood_tail++] = dst;
            seen[dst] = 1;
         end
      endfunction

      function bit [15:0] segment_image();
         bit [15:0] lbl;
         int head, q, r, c;
         lbl = 1;
         for (int p = 0; p < NPIX; p++) begin
            labels[p] = 0;
            seen[p] = 0;
         end
         for (int p = 0; p < NPIX; p++) begin
            if (seen[p] || ranges[p] == 0) begin
               continue;
            end
            head = 0;
            flood_tail = 0;
            flood[flood_tail++] = p;
            seen[p] = 1;
            while (head < flood_tail) begin
               q = flood[head++];
               r = q / COLS;
               c = q % COLS;
               labels[q] = lbl;
               for (int k = -REACH; k <= REACH; k++) begin
                  if (k == 0 || c + k < 0 || c + k >= COLS) begin
                     continue;
                  end
                  try_join(q, r * COLS + c + k, col_sin[k < 0 ? -k : k]);
               end
               for (int k = -REACH; k <= REACH; k++) begin
                  if (k == 0 || r + k < 0 || r + k >= ROWS) begin
                     continue;
                  end
                  try_join(q, (r + k) * COLS + c, row_sin[k < 0 ? r + k : r][k < 0 ? -k : k]);
               end
            end
            lbl = lbl + 1;
         end
         return lbl - 1;
      endfunction

      function void note_word(cmd_type cmd, bit [5:0] row, bit [9:0] col, bit [15:0] rng);
         bit in_image;
         int idx;
         in_image = (row < ROWS) && (col < COLS);
         idx = in_image ? row * COLS + col : 0;
         case (cmd)
            CMD_CLEAR: begin
               for (int p = 0; p < NPIX; p++) begin
                  ranges[p] = 0;
                  labels[p] = 0;
                  seen[p] = 0;
               end
            end
            CMD_LOAD: begin
               if (in_image) begin
                  ranges[idx] = rng;
               end
            end
            CMD_LABEL: begin
               pending.insert(pending.size(), segment_image());
               label_runs++;
            end
            default: begin
               pending.insert(pending.size(), in_image ? labels[idx] : 16'd0);
            end
         endcase
      endfunction

      function void check_result(bit [15:0] got);
         bit [15:0] want;
         results++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: result_value mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [5:0]  req_pixel_row;
   logic [9:0]  req_pixel_col;
   logic [15:0] req_range_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_result_value;

   label_scoreboard sb;
   bit   no_idle;
   int   words_sent;
   int   stall_left;
   int   blob_pixels[$];

   range_image_segment_labeling_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_pixel_row    (req_pixel_row),
      .req_pixel_col    (req_pixel_col),
      .req_range_value  (req_range_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (no_idle) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_result_value);
      end
   end

   task automatic send_word(cmd_type cmd, int row, int col, int rng);
      int n;
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pixel_row   <= row[5:0];
      req_pixel_col   <= col[9:0];
      req_range_value <= rng[15:0];
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_word(cmd, row[5:0], col[9:0], rng[15:0]);
      words_sent++;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // rectangle of similar ranges so that floods actually spread
   task automatic load_blob();
      int r0, c0, h, w, base, jit, v;
      r0 = $urandom_range(0, ROWS - 1);
      c0 = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1) == 1) ? COLS - 3 : 0)
                                       : $urandom_range(0, COLS - 1);
      h = $urandom_range(1, 4);
      w = $urandom_range(1, 8);
      base = $urandom_range(0, 3) == 0 ? $urandom_range(60000, 65535) : $urandom_range(200, 20000);
      for (int r = r0; r < r0 + h && r < ROWS; r++) begin
         for (int c = c0; c < c0 + w && c < COLS; c++) begin
            jit = base / 32 + 1;
            v = base + $urandom_range(0, 2 * jit) - jit;
            if (v < 1) v = 1;
            if (v > 65535) v = 65535;
            if ($urandom_range(0, 9) == 0) v = $urandom_range(1, 65535);
            send_word(CMD_LOAD, r, c, v);
            blob_pixels.insert(blob_pixels.size(), r * COLS + c);
         end
      end
   endtask

   task automatic random_phase(int load_words, int read_words);
      int p;
      blob_pixels.delete();
      no_idle = ($urandom_range(0, 3) == 0);
      while (blob_pixels.size() < load_words) begin
         if ($urandom_range(0, 4) == 0) begin
            send_word(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 1023),
                      $urandom_range(0, 65535));
            blob_pixels.insert(blob_pixels.size(), $urandom_range(0, NPIX - 1));
         end else if ($urandom_range(0, 9) == 0) begin
            send_word(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 1023), $urandom_range(0, 65535));
         end else begin
            load_blob();
         end
      end
      send_word(CMD_LABEL, $urandom_range(0, 63), $urandom_range(0, 1023), $urandom_range(0, 65535));
      no_idle = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < read_words; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            p = blob_pixels[$urandom_range(0, blob_pixels.size() - 1)];
            send_word(CMD_READ, p / COLS, p % COLS, $urandom_range(0, 65535));
         end else begin
            send_word(CMD_READ, $urandom_range(0, 63), $urandom_range(0, 1023),
                      $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_CLEAR;
      req_pixel_row = '0;
      req_pixel_col = '0;
      req_range_value = '0;
      rsp_stall = 1'b0;
      stall_left = 0;
      no_idle = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners: empty image, out-of-range column, extreme ranges
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_READ, 63, 1023, 16'hFFFF);
      send_word(CMD_LABEL, 0, 0, 0);
      send_word(CMD_LOAD, 0, 0, 16'hFFFF);
      send_word(CMD_LOAD, 0, 1, 16'hFFFF);
      send_word(CMD_LOAD, 1, 0, 16'hFF00);
      send_word(CMD_LOAD, 0, 2, 0);
      send_word(CMD_LOAD, 2, 0, 16'h8000);
      send_word(CMD_LOAD, 63, 869, 1);
      send_word(CMD_LOAD, 63, 868, 1);
      send_word(CMD_LOAD, 5, 1023, 16'h1234);
      send_word(CMD_LABEL, 0, 0, 0);
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_READ, 0, 1, 0);
      send_word(CMD_READ, 2, 0, 0);
      send_word(CMD_READ, 63, 869, 0);
      send_word(CMD_READ, 0, 2, 0);
      send_word(CMD_READ, 5, 1023, 0);
      // labels stay across loads until the next run or a clear
      send_word(CMD_LOAD, 0, 0, 16'h0100);
      send_word(CMD_READ, 0, 0, 0);
      send_word(CMD_CLEAR, 0, 0, 0);
      send_word(CMD_READ, 0, 1, 0);

      random_phase(450, 150);
      send_word(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 1023), $urandom_range(0, 65535));
      random_phase(450, 150);
      random_phase(450, 150);
      req_valid <= 1'b0;

      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (50) @(posedge clock);
      $display("Sent %0d command words, ran %0d labeling passes, checked %0d results.",
               words_sent, sb.label_runs, sb.results);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches.", sb.errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Timeout with %0d results outstanding.", sb.pending.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
